// ===== hdl/bpc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bpc_pkg
// Shared types, constants and helpers for the pressure compensation pipeline.
// ----------------------------------------------------------------------------
package bpc_pkg;

	// Configuration register indexes.
	localparam logic [3:0] BPC_REG_AC1     = 4'd0;
	localparam logic [3:0] BPC_REG_AC2     = 4'd1;
	localparam logic [3:0] BPC_REG_AC3     = 4'd2;
	localparam logic [3:0] BPC_REG_AC4     = 4'd3;
	localparam logic [3:0] BPC_REG_AC5_AC6 = 4'd4;
	localparam logic [3:0] BPC_REG_B1      = 4'd5;
	localparam logic [3:0] BPC_REG_B2      = 4'd6;
	localparam logic [3:0] BPC_REG_MC_MD   = 4'd7;

	// Calibration reset values.
	localparam logic [15:0] BPC_RST_AC1     = 16'd408;
	localparam logic [15:0] BPC_RST_AC2     = 16'hFFB8;
	localparam logic [15:0] BPC_RST_AC3     = 16'hC7D1;
	localparam logic [15:0] BPC_RST_AC4     = 16'd32741;
	localparam logic [31:0] BPC_RST_AC5_AC6 = 32'd2146785905;
	localparam logic [15:0] BPC_RST_B1      = 16'd6190;
	localparam logic [15:0] BPC_RST_B2      = 16'd4;
	localparam logic [31:0] BPC_RST_MC_MD   = 32'd3724086068;

	// Fixed coefficients of the compensation formulae.
	localparam logic [31:0] BPC_B6_OFFSET = 32'd4000;
	localparam logic [31:0] BPC_P_C1      = 32'd3038;
	localparam logic [31:0] BPC_P_C2      = 32'hFFFF_E343;
	localparam logic [31:0] BPC_P_C3      = 32'd3791;
	localparam logic [31:0] BPC_P_SCALE   = 32'd50000;
	localparam logic [31:0] BPC_B4_BIAS   = 32'd32768;

	// Number of quotient bits, one per divider stage.
	localparam int BPC_DIV_BITS = 32;

	typedef struct packed {
		logic [15:0] ac1;
		logic [15:0] ac2;
		logic [15:0] ac3;
		logic [15:0] ac4;
		logic [31:0] ac5_ac6;
		logic [15:0] b1;
		logic [15:0] b2;
		logic [31:0] mc_md;
	} cal_t;

	// Sideband that travels beside the dividers.
	typedef struct packed {
		logic        err;
		logic        neg;
		logic        dbl;
		logic [1:0]  mode;
		logic [23:0] up;
		logic [31:0] x1t;
		logic [15:0] temp;
	} ctx_t;

	// Arithmetic shift right of a 32-bit word by a constant amount.
	function automatic logic [31:0] asr32(input logic [31:0] v, input logic [4:0] n);
		asr32 = 32'($signed(v) >>> n);
	endfunction

	// Sign extension of a 16-bit calibration word.
	function automatic logic [31:0] sx16(input logic [15:0] v);
		sx16 = {{16{v[15]}}, v};
	endfunction

endpackage
`default_nettype wire

// ===== hdl/bpc_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bpc_if
// Handshake channels of the pressure compensation block.
// ----------------------------------------------------------------------------
interface bpc_in_if;
	logic        valid;
	logic        ready;
	logic [15:0] raw_temperature;
	logic [23:0] raw_pressure;
	logic [1:0]  mode;
	modport source (output valid, raw_temperature, raw_pressure, mode, input ready);
	modport sink (input valid, raw_temperature, raw_pressure, mode, output ready);
endinterface

interface bpc_out_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] temperature;
	logic signed [31:0] pressure;
	logic               divide_error;
	modport source (output valid, temperature, pressure, divide_error, input ready);
	modport sink (input valid, temperature, pressure, divide_error, output ready);
endinterface

interface bpc_cfg_if;
	logic        valid;
	logic        ready;
	logic [3:0]  index;
	logic [31:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== hdl/barometric_pressure_compensation.sv =====
`default_nettype none
// Pipeline: an accepted item passes through the two 32-stage dividers and the
// multiplier stages around them on its way to the result register.
// Throughput: one item per cycle; the whole pipeline holds while the result
// register is full and not taken.
// Reset: arst_n clears all valid bits and loads the calibration reset values.
// ----------------------------------------------------------------------------
// barometric_pressure_compensation
// Pipelined temperature and pressure compensation from raw sensor readings.
// ----------------------------------------------------------------------------
module barometric_pressure_compensation (
	input  wire        clk,
	input  wire        arst_n,
	bpc_in_if.sink     sample,
	bpc_out_if.source  result,
	bpc_cfg_if.sink    cfg
);
	import bpc_pkg::*;

	cal_t        cal;
	logic [31:0] ac1_w, ac2_w, ac3_w, ac4_w, ac5_w, ac6_w, b1_w, b2_w, mc_w, md_w;
	logic        adv;

	bpc_cal u_cal (.clk(clk), .arst_n(arst_n), .cfg(cfg), .cal(cal));

	assign ac1_w = sx16(cal.ac1);
	assign ac2_w = sx16(cal.ac2);
	assign ac3_w = sx16(cal.ac3);
	assign ac4_w = {16'h0, cal.ac4};
	assign ac5_w = {16'h0, cal.ac5_ac6[31:16]};
	assign ac6_w = {16'h0, cal.ac5_ac6[15:0]};
	assign b1_w  = sx16(cal.b1);
	assign b2_w  = sx16(cal.b2);
	assign mc_w  = sx16(cal.mc_md[31:16]);
	assign md_w  = sx16(cal.mc_md[15:0]);

	// The pipeline moves whenever the result register is free or being taken.
	logic out_v_q;
	assign adv          = !out_v_q || result.ready;
	assign sample.ready = adv;

	// Stage registers.
	logic        v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10, v_s11;
	logic        v_s12, v_s13, v_s14;
	logic [15:0] ut_s1;
	logic [23:0] rawp_s1;
	logic [1:0]  mode_s1;
	logic [31:0] x1t_s2;
	logic [23:0] up_s2;
	logic [1:0]  mode_s2;
	logic [31:0] num_s3, den_s3;
	ctx_t        ctx_s3, ctx_s4, ctx_s5, ctx_s6, ctx_s7, ctx_s8, ctx_s9, ctx_s10, ctx_s11;
	logic [31:0] b5_s4, b6_s5;
	logic [31:0] b6sq_s6, x2a_s6, x1b_s6;
	logic [31:0] x1a_s7, x2a_s7, x1b_s7, x2b_s7;
	logic [31:0] b3_s8, x3b_s8;
	logic [31:0] b4_s9, t_s9;
	logic [31:0] b4_s10, b7_s10;
	logic [31:0] num_s11, den_s11;
	logic        err_s12, err_s13, err_s14;
	logic [15:0] temp_s12, temp_s13, temp_s14;
	logic [31:0] p_s12, p_s13, p_s14, sq_s13, x2_s13, x2_s14, x1_s14;
	logic [15:0] temperature_q;
	logic [31:0] pressure_q;
	logic        err_q;

	// Divider ports.
	logic        va, vb;
	logic [31:0] qa, qb;
	ctx_t        ctxa, ctxb;

	// Temperature front end: raw offset times ac5.
	logic [31:0] d_c, prod_c;
	assign d_c    = {16'h0, ut_s1} - ac6_w;
	assign prod_c = d_c * ac5_w;

	// Signed temperature division turned into magnitudes and a sign.
	logic [31:0] tnum_c, tden_c;
	ctx_t        ctx2_c;
	assign tnum_c = {mc_w[20:0], 11'b0};
	assign tden_c = x1t_s2 + md_w;
	always_comb begin
		ctx2_c      = '0;
		ctx2_c.err  = (tden_c == '0);
		ctx2_c.neg  = tnum_c[31] ^ tden_c[31];
		ctx2_c.mode = mode_s2;
		ctx2_c.up   = up_s2;
		ctx2_c.x1t  = x1t_s2;
	end

	bpc_div u_div_t (
		.clk(clk), .arst_n(arst_n), .en(adv), .in_valid(v_s3),
		.num(num_s3), .den(den_s3), .in_ctx(ctx_s3),
		.out_valid(va), .quot(qa), .out_ctx(ctxa)
	);

	// B5, temperature and B6.
	logic [31:0] b5_c, t8_c, b6_c;
	assign b5_c = ctxa.x1t + (ctxa.neg ? (32'd0 - qa) : qa);
	assign t8_c = asr32(b5_s4 + 32'd8, 5'd4);
	assign b6_c = b5_s4 - BPC_B6_OFFSET;

	// The finished temperature joins the sideband here.
	ctx_t        ctx5_c;
	always_comb begin
		ctx5_c      = ctx_s4;
		ctx5_c.temp = t8_c[15:0];
	end

	// B3 from the first pair of correction terms.
	logic [31:0] x3_c, b3v_c, x3b_c;
	assign x3_c  = x1a_s7 + x2a_s7;
	assign b3v_c = (({ac1_w[29:0], 2'b0} + x3_c) << ctx_s7.mode) + 32'd2;
	assign x3b_c = asr32(x1b_s7 + x2b_s7 + 32'd2, 5'd2);

	// Pressure division operands; large B7 is divided first and doubled after.
	logic [31:0] scale_c;
	assign scale_c = BPC_P_SCALE >> ctx_s9.mode;

	// Sideband updates: a zero B4 flags the item, and the doubling is recorded.
	ctx_t        ctx10_c, ctx11_c;
	always_comb begin
		ctx10_c     = ctx_s9;
		ctx10_c.err = ctx_s9.err || (b4_s9 == '0);
		ctx11_c     = ctx_s10;
		ctx11_c.dbl = b7_s10[31];
	end

	bpc_div u_div_p (
		.clk(clk), .arst_n(arst_n), .en(adv), .in_valid(v_s11),
		.num(num_s11), .den(den_s11), .in_ctx(ctx_s11),
		.out_valid(vb), .quot(qb), .out_ctx(ctxb)
	);

	logic [31:0] pa_c, fin_c;
	assign pa_c  = asr32(p_s12, 5'd8);
	assign fin_c = p_s14 + asr32(x1_s14 + x2_s14 + BPC_P_C3, 5'd4);

	// Valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0; v_s5 <= 1'b0;
			v_s6 <= 1'b0; v_s7 <= 1'b0; v_s8 <= 1'b0; v_s9 <= 1'b0; v_s10 <= 1'b0;
			v_s11 <= 1'b0; v_s12 <= 1'b0; v_s13 <= 1'b0; v_s14 <= 1'b0;
			out_v_q <= 1'b0;
		end else if (adv) begin
			v_s1 <= sample.valid; v_s2 <= v_s1; v_s3 <= v_s2; v_s4 <= va;
			v_s5 <= v_s4; v_s6 <= v_s5; v_s7 <= v_s6; v_s8 <= v_s7; v_s9 <= v_s8;
			v_s10 <= v_s9; v_s11 <= v_s10; v_s12 <= vb; v_s13 <= v_s12;
			v_s14 <= v_s13; out_v_q <= v_s14;
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (adv) begin
			ut_s1   <= sample.raw_temperature;
			rawp_s1 <= sample.raw_pressure;
			mode_s1 <= sample.mode;

			x1t_s2  <= asr32(prod_c, 5'd15);
			up_s2   <= rawp_s1 >> (4'd8 - {2'b0, mode_s1});
			mode_s2 <= mode_s1;

			num_s3 <= tnum_c[31] ? (32'd0 - tnum_c) : tnum_c;
			den_s3 <= tden_c[31] ? (32'd0 - tden_c) : tden_c;
			ctx_s3 <= ctx2_c;

			b5_s4  <= b5_c;
			ctx_s4 <= ctxa;

			b6_s5  <= b6_c;
			ctx_s5 <= ctx5_c;

			b6sq_s6 <= asr32(b6_s5 * b6_s5, 5'd12);
			x2a_s6  <= asr32(ac2_w * b6_s5, 5'd11);
			x1b_s6  <= asr32(ac3_w * b6_s5, 5'd13);
			ctx_s6  <= ctx_s5;

			x1a_s7 <= asr32(b2_w * b6sq_s6, 5'd11);
			x2b_s7 <= asr32(b1_w * b6sq_s6, 5'd16);
			x2a_s7 <= x2a_s6;
			x1b_s7 <= x1b_s6;
			ctx_s7 <= ctx_s6;

			b3_s8  <= 32'($signed(b3v_c + (b3v_c[31] ? 32'd3 : 32'd0)) >>> 2);
			x3b_s8 <= x3b_c;
			ctx_s8 <= ctx_s7;

			b4_s9  <= (ac4_w * (x3b_s8 + BPC_B4_BIAS)) >> 15;
			t_s9   <= {8'h0, ctx_s8.up} - b3_s8;
			ctx_s9 <= ctx_s8;

			b7_s10  <= t_s9 * scale_c;
			b4_s10  <= b4_s9;
			ctx_s10 <= ctx10_c;

			num_s11 <= b7_s10[31] ? b7_s10 : {b7_s10[30:0], 1'b0};
			den_s11 <= b4_s10;
			ctx_s11 <= ctx11_c;

			p_s12    <= ctxb.dbl ? {qb[30:0], 1'b0} : qb;
			err_s12  <= ctxb.err;
			temp_s12 <= ctxb.temp;

			sq_s13   <= pa_c * pa_c;
			x2_s13   <= asr32(p_s12 * BPC_P_C2, 5'd16);
			p_s13    <= p_s12;
			err_s13  <= err_s12;
			temp_s13 <= temp_s12;

			x1_s14   <= asr32(sq_s13 * BPC_P_C1, 5'd16);
			x2_s14   <= x2_s13;
			p_s14    <= p_s13;
			err_s14  <= err_s13;
			temp_s14 <= temp_s13;

			temperature_q <= err_s14 ? 16'd0 : temp_s14;
			pressure_q    <= err_s14 ? 32'd0 : fin_c;
			err_q         <= err_s14;
		end
	end

	assign result.valid        = out_v_q;
	assign result.temperature  = temperature_q;
	assign result.pressure     = pressure_q;
	assign result.divide_error = err_q;

`ifndef SYNTHESIS
	// A flagged division always carries zeroed readings.
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.divide_error |->
			result.temperature == 16'sd0 && result.pressure == 32'sd0)
		else $error("divide error with non-zero readings");

	// Input is only held off by a waiting result.
	a_hold_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!sample.ready |-> result.valid && !result.ready)
		else $error("input stalled without a waiting result");

	// A stalled pipeline emits nothing new: the held result stays valid.
	a_stall_keep: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.ready |=> result.valid)
		else $error("result dropped while stalled");
`endif

endmodule
`default_nettype wire

// ===== hdl/bpc_cal.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bpc_cal
// Calibration register file, written through the configuration channel.
// ----------------------------------------------------------------------------
module bpc_cal (
	input  wire           clk,
	input  wire           arst_n,
	bpc_cfg_if.sink       cfg,
	output bpc_pkg::cal_t cal
);
	import bpc_pkg::*;

	cal_t cal_q;

	assign cfg.ready = 1'b1;
	assign cal       = cal_q;

	// Register writes; indexes past the last register are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_q.ac1     <= BPC_RST_AC1;
			cal_q.ac2     <= BPC_RST_AC2;
			cal_q.ac3     <= BPC_RST_AC3;
			cal_q.ac4     <= BPC_RST_AC4;
			cal_q.ac5_ac6 <= BPC_RST_AC5_AC6;
			cal_q.b1      <= BPC_RST_B1;
			cal_q.b2      <= BPC_RST_B2;
			cal_q.mc_md   <= BPC_RST_MC_MD;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				BPC_REG_AC1:     cal_q.ac1     <= cfg.data[15:0];
				BPC_REG_AC2:     cal_q.ac2     <= cfg.data[15:0];
				BPC_REG_AC3:     cal_q.ac3     <= cfg.data[15:0];
				BPC_REG_AC4:     cal_q.ac4     <= cfg.data[15:0];
				BPC_REG_AC5_AC6: cal_q.ac5_ac6 <= cfg.data;
				BPC_REG_B1:      cal_q.b1      <= cfg.data[15:0];
				BPC_REG_B2:      cal_q.b2      <= cfg.data[15:0];
				BPC_REG_MC_MD:   cal_q.mc_md   <= cfg.data;
				default: begin
				end
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== hdl/bpc_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bpc_div
// Pipelined unsigned 32-bit restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module bpc_div (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  en,
	input  wire                  in_valid,
	input  wire  [31:0]          num,
	input  wire  [31:0]          den,
	input  bpc_pkg::ctx_t        in_ctx,
	output logic                 out_valid,
	output logic [31:0]          quot,
	output bpc_pkg::ctx_t        out_ctx
);
	import bpc_pkg::*;

	logic        v_s   [1:BPC_DIV_BITS];
	logic [31:0] rem_s [1:BPC_DIV_BITS];
	logic [31:0] nq_s  [1:BPC_DIV_BITS];
	logic [31:0] den_s [1:BPC_DIV_BITS];
	ctx_t        ctx_s [1:BPC_DIV_BITS];

	for (genvar g = 0; g < BPC_DIV_BITS; g++) begin : g_stage
		logic        v_c;
		logic [31:0] rem_c;
		logic [31:0] nq_c;
		logic [31:0] den_c;
		ctx_t        ctx_c;
		logic [32:0] sh;
		logic [32:0] diff;
		logic        ge;

		// Stage inputs: the ports for the first stage, the previous stage after.
		if (g == 0) begin : g_first
			assign v_c   = in_valid;
			assign rem_c = '0;
			assign nq_c  = num;
			assign den_c = den;
			assign ctx_c = in_ctx;
		end else begin : g_next
			assign v_c   = v_s[g];
			assign rem_c = rem_s[g];
			assign nq_c  = nq_s[g];
			assign den_c = den_s[g];
			assign ctx_c = ctx_s[g];
		end

		// Bring down one numerator bit and try to subtract the divisor.
		assign sh   = {rem_c, nq_c[31]};
		assign diff = sh - {1'b0, den_c};
		assign ge   = (sh >= {1'b0, den_c});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[g+1] <= 1'b0;
			end else if (en) begin
				v_s[g+1] <= v_c;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[g+1] <= ge ? diff[31:0] : sh[31:0];
				nq_s[g+1]  <= {nq_c[30:0], ge};
				den_s[g+1] <= den_c;
				ctx_s[g+1] <= ctx_c;
			end
		end
	end

	assign out_valid = v_s[BPC_DIV_BITS];
	assign quot      = nq_s[BPC_DIV_BITS];
	assign out_ctx   = ctx_s[BPC_DIV_BITS];

endmodule
`default_nettype wire
